### rtl/vatb_pkg.sv
`default_nettype none
package vatb_pkg;

  localparam int COEF_W    = 20;
  localparam int FRAC_BITS = 16;
  localparam int OFFSET_W  = 32;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int NUM_AXES  = 3;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_X    = 3'd0,
    REG_ROW_Y    = 3'd1,
    REG_ROW_Z    = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } reg_idx_t;

  // Identity matrix in Q4.16: 1.0 on the diagonal of each row.
  localparam logic [ROW_W-1:0] ROW_X_RESET = 60'h0000000_00010000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 60'h0000010_00000000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 60'h1000000_00000000;

endpackage
`default_nettype wire

### rtl/vatb_stream_if.sv
`default_nettype none
interface vatb_vertex_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;
  logic                          last_vertex;

  modport source (output valid, output in_x, output in_y, output in_z,
                  output last_vertex, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z,
                  input last_vertex, output ready);
endinterface

interface vatb_result_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic                          box_final;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output box_min_x, output box_max_x, output box_min_y,
                  output box_max_y, output box_min_z, output box_max_z,
                  output box_final, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input box_min_x, input box_max_x, input box_min_y,
                  input box_max_y, input box_min_z, input box_max_z,
                  input box_final, output ready);
endinterface
`default_nettype wire

### rtl/vertex_affine_transform_bbox.sv
`default_nettype none
// Affine vertex transform with a running bounding box. Each beat on vertex_in
// carries one Q16.16 vertex; the matching beat on result_out carries
// M*v + offset, rounded to nearest (ties up) and saturated to COORD_WIDTH
// bits, together with the min/max box of all vertices of the current set so
// far. A vertex marked last yields box_final and starts a fresh box. The
// block takes one vertex per clock unless result_out stalls it. Each vertex
// passes five register stages: input register, the nine coefficient
// products, the three-term sum with rounding, the offset add and clamp,
// and the box compare into the output register. A stage holds its item
// only while the stage after it is full and stalled, so bubbles are
// squeezed out under backpressure.
// The six registers sit on a 64-bit APB port at byte offsets 0x00 to 0x28
// (rows x, y, z, then offsets x, y, z) and should be written only while the
// pipeline is empty.
module vertex_affine_transform_bbox #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [vatb_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [vatb_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [vatb_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  vatb_vertex_if.sink                          vertex_in,
  vatb_result_if.source                        result_out
);

  localparam int W       = COORD_WIDTH;
  localparam int CW      = vatb_pkg::COEF_W;
  localparam int FB      = vatb_pkg::FRAC_BITS;
  localparam int OW      = vatb_pkg::OFFSET_W;
  localparam int NA      = vatb_pkg::NUM_AXES;
  localparam int PROD_W  = W + CW;
  localparam int SUM_W   = PROD_W + 2;
  localparam int RND_W   = SUM_W - FB;
  localparam int ACC_W   = ((RND_W > OW) ? RND_W : OW) + 1;

  localparam logic signed [SUM_W-1:0] ROUND_HALF =
    {{(SUM_W-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]     CW_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]     CW_MIN = {1'b1, {(W-1){1'b0}}};

  // ---------------------------------------------------------------- registers
  logic [vatb_pkg::ROW_W-1:0] row  [NA];
  logic signed [OW-1:0]       offs [NA];

  vatb_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  assign reg_idx   = vatb_pkg::reg_idx_t'(paddr[vatb_pkg::APB_ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0]  <= vatb_pkg::ROW_X_RESET;
      row[1]  <= vatb_pkg::ROW_Y_RESET;
      row[2]  <= vatb_pkg::ROW_Z_RESET;
      offs[0] <= '0;
      offs[1] <= '0;
      offs[2] <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        vatb_pkg::REG_ROW_X:    row[0]  <= pwdata[vatb_pkg::ROW_W-1:0];
        vatb_pkg::REG_ROW_Y:    row[1]  <= pwdata[vatb_pkg::ROW_W-1:0];
        vatb_pkg::REG_ROW_Z:    row[2]  <= pwdata[vatb_pkg::ROW_W-1:0];
        vatb_pkg::REG_OFFSET_X: offs[0] <= pwdata[OW-1:0];
        vatb_pkg::REG_OFFSET_Y: offs[1] <= pwdata[OW-1:0];
        vatb_pkg::REG_OFFSET_Z: offs[2] <= pwdata[OW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vatb_pkg::REG_ROW_X:    prdata = vatb_pkg::APB_DATA_W'(row[0]);
      vatb_pkg::REG_ROW_Y:    prdata = vatb_pkg::APB_DATA_W'(row[1]);
      vatb_pkg::REG_ROW_Z:    prdata = vatb_pkg::APB_DATA_W'(row[2]);
      vatb_pkg::REG_OFFSET_X: prdata = {{(vatb_pkg::APB_DATA_W-OW){1'b0}}, offs[0]};
      vatb_pkg::REG_OFFSET_Y: prdata = {{(vatb_pkg::APB_DATA_W-OW){1'b0}}, offs[1]};
      vatb_pkg::REG_OFFSET_Z: prdata = {{(vatb_pkg::APB_DATA_W-OW){1'b0}}, offs[2]};
      default:                prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ stage control
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || result_out.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign vertex_in.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= vertex_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // ------------------------------------------------------------ stage 1: input
  logic signed [W-1:0] x1 [NA];
  logic                last1;

  always_ff @(posedge clk) begin
    if (rdy1 && vertex_in.valid) begin
      x1[0] <= vertex_in.in_x;
      x1[1] <= vertex_in.in_y;
      x1[2] <= vertex_in.in_z;
      last1 <= vertex_in.last_vertex;
    end
  end

  // --------------------------------------------------------- stage 2: products
  logic signed [PROD_W-1:0] prod2 [NA][NA];
  logic                     last2;
  logic signed [CW-1:0]     coef  [NA][NA];

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      for (int k = 0; k < NA; k++) begin
        coef[r][k] = row[r][CW*k +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int r = 0; r < NA; r++) begin
        for (int k = 0; k < NA; k++) begin
          prod2[r][k] <= PROD_W'(coef[r][k]) * PROD_W'(x1[k]);
        end
      end
      last2 <= last1;
    end
  end

  // ---------------------------------------------------- stage 3: sum and round
  logic signed [SUM_W-1:0] sum3 [NA];
  logic signed [RND_W-1:0] rnd3 [NA];
  logic                    last3;

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      sum3[r] = SUM_W'(prod2[r][0]) + SUM_W'(prod2[r][1]) + SUM_W'(prod2[r][2])
              + ROUND_HALF;
    end
  end

  // Dropping the fraction bits of a two's complement sum is a floor divide.
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int r = 0; r < NA; r++) begin
        rnd3[r] <= sum3[r][SUM_W-1:FB];
      end
      last3 <= last2;
    end
  end

  // -------------------------------------------------- stage 4: offset and clamp
  logic signed [ACC_W-1:0] acc4 [NA];
  logic signed [W-1:0]     res4 [NA];
  logic                    last4;

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      acc4[r] = ACC_W'(rnd3[r]) + ACC_W'(offs[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int r = 0; r < NA; r++) begin
        if (acc4[r] > SAT_HI) begin
          res4[r] <= CW_MAX;
        end else if (acc4[r] < SAT_LO) begin
          res4[r] <= CW_MIN;
        end else begin
          res4[r] <= acc4[r][W-1:0];
        end
      end
      last4 <= last3;
    end
  end

  // ------------------------------------------------ stage 5: box and output
  logic signed [W-1:0] run_min      [NA];
  logic signed [W-1:0] run_max      [NA];
  logic signed [W-1:0] run_min_next [NA];
  logic signed [W-1:0] run_max_next [NA];
  logic signed [W-1:0] res5         [NA];
  logic signed [W-1:0] bmin5        [NA];
  logic signed [W-1:0] bmax5        [NA];
  logic                last5;
  logic                ld5;

  assign ld5 = rdy5 && v4;

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      run_min_next[r] = (res4[r] < run_min[r]) ? res4[r] : run_min[r];
      run_max_next[r] = (res4[r] > run_max[r]) ? res4[r] : run_max[r];
    end
  end

  // The box state moves in step with items entering the output register,
  // so it always reflects every vertex of the current set ahead of the one in stage 4.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NA; r++) begin
        run_min[r] <= CW_MAX;
        run_max[r] <= CW_MIN;
      end
    end else if (ld5) begin
      for (int r = 0; r < NA; r++) begin
        run_min[r] <= last4 ? CW_MAX : run_min_next[r];
        run_max[r] <= last4 ? CW_MIN : run_max_next[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      for (int r = 0; r < NA; r++) begin
        res5[r]  <= res4[r];
        bmin5[r] <= run_min_next[r];
        bmax5[r] <= run_max_next[r];
      end
      last5 <= last4;
    end
  end

  assign result_out.valid     = v5;
  assign result_out.out_x     = res5[0];
  assign result_out.out_y     = res5[1];
  assign result_out.out_z     = res5[2];
  assign result_out.box_min_x = bmin5[0];
  assign result_out.box_max_x = bmax5[0];
  assign result_out.box_min_y = bmin5[1];
  assign result_out.box_max_y = bmax5[1];
  assign result_out.box_min_z = bmin5[2];
  assign result_out.box_max_z = bmax5[2];
  assign result_out.box_final = last5;

  // --------------------------------------------------------------- assertions
  a_box_restart: assert property (@(posedge clk) disable iff (rst)
    (ld5 && last4) |=> (run_min[0] == CW_MAX && run_max[0] == CW_MIN &&
                        run_min[2] == CW_MAX && run_max[2] == CW_MIN))
    else $error("box state not cleared after last vertex");

  a_box_covers_x: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (bmin5[0] <= res5[0] && res5[0] <= bmax5[0]))
    else $error("reported x box does not contain the vertex");

  a_box_covers_y: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (bmin5[1] <= res5[1] && res5[1] <= bmax5[1]))
    else $error("reported y box does not contain the vertex");

  a_no_stuck_bubble: assert property (@(posedge clk) disable iff (rst)
    (v4 && !v5) |=> v5)
    else $error("stage 4 item did not advance into an empty output register");

endmodule
`default_nettype wire
